FILE: rtl/core/qepg_pkg.sv
// qepg_pkg: shared types and constants for the quad esc pulse generator
// no dependencies; used by every file under rtl/core except qepg_if

package qepg_pkg;

    // number of pulse channels (front left, front right, rear left, rear right)
    localparam int NUM_CHAN = 4;

    // channel slots in the width and level vectors
    localparam int CH_FRONT_LEFT  = 0;
    localparam int CH_FRONT_RIGHT = 1;
    localparam int CH_REAR_LEFT   = 2;
    localparam int CH_REAR_RIGHT  = 3;

    // register reset values in ticks
    localparam int MIN_WIDTH_RESET = 1000;
    localparam int MAX_WIDTH_RESET = 2000;
    localparam int FRAME_GAP_RESET = 500;

    // apb port geometry
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register index (word address)
    typedef enum logic [1:0] {
        REG_MIN_WIDTH = 2'd0,
        REG_MAX_WIDTH = 2'd1,
        REG_FRAME_GAP = 2'd2
    } t_reg_idx;

    // handshake control between the pipeline controller and the datapath
    typedef struct packed {
        logic s1_load;   // input register takes a new transfer
        logic advance;   // input register moves into the result register
    } t_pipe_ctl;

endpackage

FILE: rtl/core/qepg_if.sv
// qepg_if: valid/ready channel interfaces for width requests and pulse levels
// depends on nothing; instantiated around quad_esc_pulse_generator_core

interface qepg_in_if #(
    parameter int WIDTH_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [WIDTH_BITS-1:0] front_left_width;
    logic [WIDTH_BITS-1:0] front_right_width;
    logic [WIDTH_BITS-1:0] rear_left_width;
    logic [WIDTH_BITS-1:0] rear_right_width;

    modport source (
        output valid, front_left_width, front_right_width,
               rear_left_width, rear_right_width,
        input  ready
    );
    modport sink (
        input  valid, front_left_width, front_right_width,
               rear_left_width, rear_right_width,
        output ready
    );
endinterface

interface qepg_out_if;
    logic valid;
    logic ready;
    logic front_left_level;
    logic front_right_level;
    logic rear_left_level;
    logic rear_right_level;
    logic frame_start;

    modport source (
        output valid, front_left_level, front_right_level,
               rear_left_level, rear_right_level, frame_start,
        input  ready
    );
    modport sink (
        input  valid, front_left_level, front_right_level,
               rear_left_level, rear_right_level, frame_start,
        output ready
    );
endinterface

FILE: rtl/core/qepg_cfg_regs.sv
// qepg_cfg_regs: apb register file for min_width, max_width and frame_gap
// depends on qepg_pkg

module qepg_cfg_regs #(
    parameter int WIDTH_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [qepg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [qepg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [qepg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [WIDTH_BITS-1:0]            o_min_width,
    output logic [WIDTH_BITS-1:0]            o_max_width,
    output logic [WIDTH_BITS-1:0]            o_frame_gap
);

    logic [WIDTH_BITS-1:0] r_min_width;
    logic [WIDTH_BITS-1:0] r_max_width;
    logic [WIDTH_BITS-1:0] r_frame_gap;
    logic                  wr_en;
    qepg_pkg::t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = qepg_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= WIDTH_BITS'(qepg_pkg::MIN_WIDTH_RESET);
            r_max_width <= WIDTH_BITS'(qepg_pkg::MAX_WIDTH_RESET);
            r_frame_gap <= WIDTH_BITS'(qepg_pkg::FRAME_GAP_RESET);
        end else if (wr_en) begin
            case (reg_idx)
                qepg_pkg::REG_MIN_WIDTH: r_min_width <= pwdata[WIDTH_BITS-1:0];
                qepg_pkg::REG_MAX_WIDTH: r_max_width <= pwdata[WIDTH_BITS-1:0];
                qepg_pkg::REG_FRAME_GAP: r_frame_gap <= pwdata[WIDTH_BITS-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            qepg_pkg::REG_MIN_WIDTH: prdata = qepg_pkg::APB_DATA_W'(r_min_width);
            qepg_pkg::REG_MAX_WIDTH: prdata = qepg_pkg::APB_DATA_W'(r_max_width);
            qepg_pkg::REG_FRAME_GAP: prdata = qepg_pkg::APB_DATA_W'(r_frame_gap);
            default:                 prdata = '0;
        endcase
    end

    assign o_min_width = r_min_width;
    assign o_max_width = r_max_width;
    assign o_frame_gap = r_frame_gap;

endmodule

FILE: rtl/core/qepg_pipe_ctrl.sv
// qepg_pipe_ctrl: valid tracking for the input and result registers
// depends on qepg_pkg

module qepg_pipe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_s1_valid,
    output logic                o_out_valid,
    output qepg_pkg::t_pipe_ctl o_ctl
);

    logic r_s1_valid;
    logic r_out_valid;
    logic n_s1_valid;
    logic n_out_valid;
    logic advance;
    logic in_ready;

    // result register frees up when empty or being taken this cycle
    assign advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign in_ready = !r_s1_valid || advance;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (i_in_valid && in_ready) begin
            n_s1_valid = 1'b1;
        end else if (advance) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_s1_valid    = r_s1_valid;
    assign o_out_valid   = r_out_valid;
    assign o_ctl.s1_load = i_in_valid && in_ready;
    assign o_ctl.advance = advance;

endmodule

FILE: rtl/core/qepg_frame_engine.sv
// qepg_frame_engine: frame tick counter, width clamp/latch and level compare
// depends on qepg_pkg

module qepg_frame_engine #(
    parameter int WIDTH_BITS = 12
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_step,
    input  logic [qepg_pkg::NUM_CHAN-1:0][WIDTH_BITS-1:0] i_width,
    input  logic [WIDTH_BITS-1:0]                        i_min_width,
    input  logic [WIDTH_BITS-1:0]                        i_max_width,
    input  logic [WIDTH_BITS-1:0]                        i_frame_gap,
    output logic [qepg_pkg::NUM_CHAN-1:0]                o_level,
    output logic                                         o_frame_start
);

    localparam int TW = WIDTH_BITS + 1;

    logic [TW-1:0]                                   r_frame_tick;
    logic [TW-1:0]                                   n_frame_tick;
    logic [qepg_pkg::NUM_CHAN-1:0][WIDTH_BITS-1:0]   r_latched;
    logic [qepg_pkg::NUM_CHAN-1:0][WIDTH_BITS-1:0]   clamped;
    logic [qepg_pkg::NUM_CHAN-1:0][WIDTH_BITS-1:0]   eff_width;
    logic [TW-1:0]                                   frame_len_raw;
    logic [TW-1:0]                                   frame_len;
    logic [TW:0]                                     tick_inc;
    logic                                            start;

    assign start         = (r_frame_tick == '0);
    assign frame_len_raw = {1'b0, i_max_width} + {1'b0, i_frame_gap};
    // zero length frame behaves as one tick
    assign frame_len     = (frame_len_raw == '0) ? TW'(1) : frame_len_raw;
    assign tick_inc      = {1'b0, r_frame_tick} + (TW+1)'(1);

    always_comb begin
        for (int k = 0; k < qepg_pkg::NUM_CHAN; k++) begin
            // upper test first, so an inverted range favors max_width
            if (i_width[k] > i_max_width) begin
                clamped[k] = i_max_width;
            end else if (i_width[k] < i_min_width) begin
                clamped[k] = i_min_width;
            end else begin
                clamped[k] = i_width[k];
            end
            eff_width[k] = start ? clamped[k] : r_latched[k];
            o_level[k]   = (r_frame_tick <= {1'b0, eff_width[k]});
        end
    end

    assign n_frame_tick  = (tick_inc >= {1'b0, frame_len}) ? '0 : tick_inc[TW-1:0];
    assign o_frame_start = start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_tick <= '0;
            r_latched    <= '0;
        end else if (i_step) begin
            r_frame_tick <= n_frame_tick;
            if (start) begin
                r_latched <= clamped;
            end
        end
    end

endmodule

FILE: rtl/core/quad_esc_pulse_generator_core.sv
// quad_esc_pulse_generator_core: four-channel rc servo style pulse generator
// flow: a width transfer is taken into the input register, then moves into the result register on o_out_ch
// throughput: one tick transfer per clock while o_out_ch is not blocked, set by the input and result registers
// reset: i_rst_n synchronous active low; registers return to 1000/2000/500 ticks,
// the frame counter clears so the first tick after reset starts a frame
// depends on qepg_pkg, qepg_if, qepg_cfg_regs, qepg_pipe_ctrl, qepg_frame_engine

module quad_esc_pulse_generator_core #(
    parameter int WIDTH_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // apb configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [qepg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [qepg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [qepg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // tick channel carrying the four requested widths
    qepg_in_if.sink                          i_in_ch,
    // result channel carrying the four levels and the frame start flag
    qepg_out_if.source                       o_out_ch
);

    // configuration values
    logic [WIDTH_BITS-1:0] min_width;
    logic [WIDTH_BITS-1:0] max_width;
    logic [WIDTH_BITS-1:0] frame_gap;

    // handshake control
    qepg_pkg::t_pipe_ctl   ctl;
    logic                  in_ready;
    logic                  s1_valid;
    logic                  out_valid;

    // input register: the tick's four requested widths
    logic [qepg_pkg::NUM_CHAN-1:0][WIDTH_BITS-1:0] r_s1_width;

    // engine results for the tick sitting in the input register
    logic [qepg_pkg::NUM_CHAN-1:0] eng_level;
    logic                          eng_frame_start;

    // result register
    logic [qepg_pkg::NUM_CHAN-1:0] r_level;
    logic                          r_frame_start;

    qepg_cfg_regs #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_min_width (min_width),
        .o_max_width (max_width),
        .o_frame_gap (frame_gap)
    );

    qepg_pipe_ctrl u_pipe_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_in_ready  (in_ready),
        .o_s1_valid  (s1_valid),
        .o_out_valid (out_valid),
        .o_ctl       (ctl)
    );

    // capture the widths of an accepted tick transfer
    always_ff @(posedge i_clk) begin
        if (ctl.s1_load) begin
            r_s1_width[qepg_pkg::CH_FRONT_LEFT]  <= i_in_ch.front_left_width;
            r_s1_width[qepg_pkg::CH_FRONT_RIGHT] <= i_in_ch.front_right_width;
            r_s1_width[qepg_pkg::CH_REAR_LEFT]   <= i_in_ch.rear_left_width;
            r_s1_width[qepg_pkg::CH_REAR_RIGHT]  <= i_in_ch.rear_right_width;
        end
    end

    // frame state only steps when the tick moves into the result register,
    // so a stalled output never skips or repeats a tick
    qepg_frame_engine #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_frame_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (ctl.advance),
        .i_width       (r_s1_width),
        .i_min_width   (min_width),
        .i_max_width   (max_width),
        .i_frame_gap   (frame_gap),
        .o_level       (eng_level),
        .o_frame_start (eng_frame_start)
    );

    always_ff @(posedge i_clk) begin
        if (ctl.advance) begin
            r_level       <= eng_level;
            r_frame_start <= eng_frame_start;
        end
    end

    assign i_in_ch.ready              = in_ready;
    assign o_out_ch.valid             = out_valid;
    assign o_out_ch.front_left_level  = r_level[qepg_pkg::CH_FRONT_LEFT];
    assign o_out_ch.front_right_level = r_level[qepg_pkg::CH_FRONT_RIGHT];
    assign o_out_ch.rear_left_level   = r_level[qepg_pkg::CH_REAR_LEFT];
    assign o_out_ch.rear_right_level  = r_level[qepg_pkg::CH_REAR_RIGHT];
    assign o_out_ch.frame_start       = r_frame_start;

    // every channel is high on the tick that opens a frame
    a_start_all_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && r_frame_start |-> (r_level == '1))
        else $error("frame start transfer with a low channel");

    // input side only stalls when both registers hold a tick and the output is blocked
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (s1_valid && out_valid && !o_out_ch.ready))
        else $error("input stalled without a full pipeline");

    // within a frame a channel can only fall, never rise
    a_no_mid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.advance && !eng_frame_start |-> ((eng_level & ~r_level) == '0))
        else $error("channel rose in the middle of a frame");

endmodule

FILE: tb/qepg_checker.sv
`timescale 1ns / 1ps
// qepg_checker: watches the apb port and both channels of the pulse generator,
// predicts every level transfer and compares it field by field
// depends on qepg_pkg and the qepg_in_if / qepg_out_if interfaces

module qepg_checker #(
    parameter int WIDTH_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [qepg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [qepg_pkg::APB_DATA_W-1:0]  pwdata,
    qepg_in_if                               i_in_ch,
    qepg_out_if                              i_out_ch,
    output int                               o_pending,
    output int                               o_fail_count
);
    import qepg_pkg::*;

    typedef struct packed {
        logic [NUM_CHAN-1:0] level;
        logic                frame_start;
    } pulse_t;

    localparam string CHAN_NAME [NUM_CHAN] =
        '{"front_left", "front_right", "rear_left", "rear_right"};

    // shadow registers and frame state
    logic [WIDTH_BITS-1:0] min_w;
    logic [WIDTH_BITS-1:0] max_w;
    logic [WIDTH_BITS-1:0] gap_w;
    logic [WIDTH_BITS:0]   tick_cnt;
    logic [WIDTH_BITS-1:0] held_w [NUM_CHAN];

    pulse_t level_q [$];
    int     fails = 0;

    function automatic logic [WIDTH_BITS-1:0] clamp_request(input logic [WIDTH_BITS-1:0] req);
        // upper bound wins when the range is inverted
        if (req > max_w) return max_w;
        if (req < min_w) return min_w;
        return req;
    endfunction

    task automatic note_fail(input string what, input logic [3:0] want, input logic [3:0] got);
        fails++;
        if (fails <= 10) begin
            $display("[%0t] mismatch %s: expected %0h got %0h", $time, what, want, got);
        end
    endtask

    // expected levels of one tick, advancing the frame counter
    function automatic pulse_t predict_tick(input logic [WIDTH_BITS-1:0] req [NUM_CHAN]);
        pulse_t want;
        int     frame_len;
        frame_len = int'(max_w) + int'(gap_w);
        if (frame_len == 0) frame_len = 1;
        want.frame_start = (tick_cnt == '0);
        if (want.frame_start) begin
            for (int k = 0; k < NUM_CHAN; k++) held_w[k] = clamp_request(req[k]);
        end
        for (int k = 0; k < NUM_CHAN; k++) want.level[k] = (tick_cnt <= held_w[k]);
        if (int'(tick_cnt) + 1 >= frame_len) tick_cnt = '0;
        else tick_cnt = tick_cnt + 1'b1;
        return want;
    endfunction

    always @(posedge i_clk) begin : watch
        pulse_t                got;
        pulse_t                want;
        logic [WIDTH_BITS-1:0] req [NUM_CHAN];
        if (!i_rst_n) begin
            min_w    = WIDTH_BITS'(MIN_WIDTH_RESET);
            max_w    = WIDTH_BITS'(MAX_WIDTH_RESET);
            gap_w    = WIDTH_BITS'(FRAME_GAP_RESET);
            tick_cnt = '0;
            for (int k = 0; k < NUM_CHAN; k++) held_w[k] = '0;
            level_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_ADDR_W-1:2]))
                    REG_MIN_WIDTH: min_w = pwdata[WIDTH_BITS-1:0];
                    REG_MAX_WIDTH: max_w = pwdata[WIDTH_BITS-1:0];
                    REG_FRAME_GAP: gap_w = pwdata[WIDTH_BITS-1:0];
                    default: ;
                endcase
            end
            // results first, so a tick taken at this edge cannot pair with them
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.level[CH_FRONT_LEFT]  = i_out_ch.front_left_level;
                got.level[CH_FRONT_RIGHT] = i_out_ch.front_right_level;
                got.level[CH_REAR_LEFT]   = i_out_ch.rear_left_level;
                got.level[CH_REAR_RIGHT]  = i_out_ch.rear_right_level;
                got.frame_start           = i_out_ch.frame_start;
                if (level_q.size() == 0) begin
                    note_fail("unexpected level transfer", '0, got.level);
                end else begin
                    want = level_q.pop_front();
                    for (int k = 0; k < NUM_CHAN; k++) begin
                        if (got.level[k] !== want.level[k])
                            note_fail({CHAN_NAME[k], "_level"}, 4'(want.level[k]),
                                      4'(got.level[k]));
                    end
                    if (got.frame_start !== want.frame_start)
                        note_fail("frame_start", 4'(want.frame_start), 4'(got.frame_start));
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                req[CH_FRONT_LEFT]  = i_in_ch.front_left_width;
                req[CH_FRONT_RIGHT] = i_in_ch.front_right_width;
                req[CH_REAR_LEFT]   = i_in_ch.rear_left_width;
                req[CH_REAR_RIGHT]  = i_in_ch.rear_right_width;
                level_q.push_back(predict_tick(req));
            end
        end
        o_pending    <= level_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/tb_quad_esc_pulse_generator_core.sv
`timescale 1ns / 1ps
// tb_quad_esc_pulse_generator_core: drives ticks and register writes into the
// pulse generator and gives the verdict; depends on qepg_pkg, qepg_if, qepg_checker

module tb_quad_esc_pulse_generator_core;
    import qepg_pkg::*;

    localparam int         WIDTH_BITS   = 12;
    localparam int         CLK_PERIOD   = 10;
    localparam int         RESET_CYCLES = 2;
    localparam int         TARGET_TICKS = 450;
    localparam int         LONG_HOLD    = 64;      // receiver hold-off, well past any buffering
    localparam int         DRAIN_CYCLES = 4;       // settle margin after the last transfer
    localparam int         CYCLE_LIMIT  = 400000;
    localparam logic [1:0] UNUSED_REG   = 2'd3;    // index past the last register

    logic i_clk = 1'b0;
    logic i_rst_n;

    // apb configuration port
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    qepg_in_if #(.WIDTH_BITS(WIDTH_BITS)) tick_ch ();
    qepg_out_if                           level_ch ();

    int pending;
    int fail_count;
    int cycles = 0;

    // sender burst mode: no gaps between ticks while set
    bit tx_eager = 1'b0;
    // tracks max_width so random requests land around the clamp window
    int shadow_max = MAX_WIDTH_RESET;
    // long receiver hold-off requests, acknowledged by the receiver process
    int hold_req = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    quad_esc_pulse_generator_core #(
        .WIDTH_BITS (WIDTH_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_in_ch  (tick_ch),
        .o_out_ch (level_ch)
    );

    qepg_checker #(
        .WIDTH_BITS (WIDTH_BITS)
    ) pulse_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .i_in_ch      (tick_ch),
        .i_out_ch     (level_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // watchdog: a hung handshake or missing levels end the run here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL quad_esc_pulse_generator_core");
            $finish;
        end
    end

    // apb write: setup cycle, access cycle, then the bus returns to idle
    // upper data bits are random, only the low register bits must stick
    task automatic write_reg(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_F000) | (value & 32'h0000_0FFF);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MAX_WIDTH) shadow_max = value;
        @(posedge i_clk);
    endtask

    // offer one tick, returning at the edge of its transfer
    task automatic send_tick(input logic [WIDTH_BITS-1:0] fl, input logic [WIDTH_BITS-1:0] fr,
                             input logic [WIDTH_BITS-1:0] rl, input logic [WIDTH_BITS-1:0] rr);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid             <= 1'b1;
        tick_ch.front_left_width  <= fl;
        tick_ch.front_right_width <= fr;
        tick_ch.rear_left_width   <= rl;
        tick_ch.rear_right_width  <= rr;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
    endtask

    // stop offering and wait until every predicted level transfer has arrived
    task automatic wait_drained();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly around the clamp window, a quarter of them anywhere in the field
    function automatic logic [WIDTH_BITS-1:0] draw_width();
        int span;
        span = (shadow_max + 3 > 4095) ? 4095 : shadow_max + 3;
        if ($urandom_range(0, 3) == 0) return WIDTH_BITS'($urandom());
        return WIDTH_BITS'($urandom_range(0, span));
    endfunction

    // level receiver: random stalls, burst stretches, and a long hold on request
    initial begin : level_sink
        int hold;
        int taken;
        int hold_done;
        bit rx_eager;
        taken     = 0;
        hold_done = 0;
        rx_eager  = 1'b0;
        level_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (taken % 32 == 0) rx_eager = ($urandom_range(0, 2) == 0);
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                hold      = LONG_HOLD;
            end else begin
                hold = rx_eager ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0) begin
                level_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            level_ch.ready <= 1'b1;
            do @(posedge i_clk); while (level_ch.valid !== 1'b1);
            taken++;
        end
    end

    initial begin : stimulus
        int sent;
        int phase;
        int kind;
        int n_ticks;
        int new_min;
        int new_max;
        int new_gap;
        sent  = 0;
        phase = 0;

        // every input known from time zero
        i_rst_n                   <= 1'b0;
        psel                      <= 1'b0;
        penable                   <= 1'b0;
        pwrite                    <= 1'b0;
        paddr                     <= '0;
        pwdata                    <= '0;
        tick_ch.valid             <= 1'b0;
        tick_ch.front_left_width  <= '0;
        tick_ch.front_right_width <= '0;
        tick_ch.rear_left_width   <= '0;
        tick_ch.rear_right_width  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values 1000/2000/500: first tick starts a frame and clamps both ways
        send_tick(12'd0, 12'd4095, 12'd1000, 12'd2000);
        send_tick(12'd1500, 12'd999, 12'd2001, 12'd4095);
        send_tick(12'd0, 12'd0, 12'd0, 12'd0);
        send_tick(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        wait_drained();

        // shrink the frame below the current tick count, min above max as well
        write_reg(REG_MAX_WIDTH, 1);
        write_reg(REG_FRAME_GAP, 1);
        send_tick(12'd0, 12'd1, 12'd2, 12'd4095);
        send_tick(12'd5, 12'd0, 12'd4095, 12'd1);
        send_tick(12'd1, 12'd1, 12'd1, 12'd1);
        send_tick(12'd0, 12'd4095, 12'd0, 12'd4095);
        wait_drained();

        // zero frame length: every tick opens a frame
        write_reg(REG_MIN_WIDTH, 0);
        write_reg(REG_MAX_WIDTH, 0);
        write_reg(REG_FRAME_GAP, 0);
        send_tick(12'd4095, 12'd0, 12'd2730, 12'd1365);
        send_tick(12'd1365, 12'd2730, 12'd0, 12'd4095);
        send_tick(12'd1, 12'd2, 12'd3, 12'd4);
        wait_drained();

        // short frames, every pulse edge visible within a few ticks
        write_reg(REG_MIN_WIDTH, 2);
        write_reg(REG_MAX_WIDTH, 6);
        write_reg(REG_FRAME_GAP, 1);
        send_tick(12'd0, 12'd4095, 12'd3, 12'd6);
        send_tick(12'd2, 12'd5, 12'd7, 12'd1);
        send_tick(12'd4, 12'd4, 12'd4, 12'd4);
        send_tick(12'd6, 12'd2, 12'd0, 12'd3);
        send_tick(12'd1, 12'd3, 12'd5, 12'd4095);
        send_tick(12'd0, 12'd6, 12'd2, 12'd5);
        send_tick(12'd3, 12'd0, 12'd6, 12'd2);
        send_tick(12'd5, 12'd1, 12'd4, 12'd0);
        wait_drained();

        // full width window and longest frame; the unused index must not alias
        write_reg(REG_MIN_WIDTH, 0);
        write_reg(REG_MAX_WIDTH, 4095);
        write_reg(REG_FRAME_GAP, 4095);
        write_reg(UNUSED_REG, 1);
        send_tick(12'd0, 12'd1, 12'd4094, 12'd4095);
        send_tick(12'd4095, 12'd4094, 12'd1, 12'd0);
        send_tick(12'd2048, 12'd2047, 12'd1024, 12'd3072);
        sent = 22;

        // random phases, each opened from an idle block with a new max_width and mostly new other registers
        while (sent < TARGET_TICKS) begin
            wait_drained();
            kind    = $urandom_range(0, 9);
            n_ticks = $urandom_range(20, 50);
            case (kind)
                0: begin   // both bounds at the top
                    new_min = 4095;
                    new_max = 4095;
                    new_gap = $urandom_range(0, 4095);
                    n_ticks = 8;
                end
                1: begin   // inverted window
                    new_min = $urandom_range(5, 40);
                    new_max = $urandom_range(0, 4);
                    new_gap = $urandom_range(1, 6);
                end
                2: begin   // longest frame
                    new_min = 0;
                    new_max = 4095;
                    new_gap = 4095;
                    n_ticks = 8;
                end
                3: begin   // zero max, frames of one or two ticks
                    new_min = $urandom_range(0, 4095);
                    new_max = 0;
                    new_gap = $urandom_range(0, 2);
                end
                default: begin
                    new_min = $urandom_range(0, 12);
                    new_max = $urandom_range(0, 24);
                    new_gap = $urandom_range(0, 8);
                end
            endcase
            if ($urandom_range(0, 3) != 0) write_reg(REG_MIN_WIDTH, new_min);
            write_reg(REG_MAX_WIDTH, new_max);
            if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_GAP, new_gap);
            if ($urandom_range(0, 7) == 0) write_reg(UNUSED_REG, $urandom_range(0, 4095));
            tx_eager = ($urandom_range(0, 3) == 0);
            // one phase keeps offering ticks while the receiver holds off
            if (phase == 2) begin
                tx_eager = 1'b1;
                n_ticks  = 60;
                hold_req <= hold_req + 1;
            end
            repeat (n_ticks) begin
                send_tick(draw_width(), draw_width(), draw_width(), draw_width());
                sent++;
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS quad_esc_pulse_generator_core");
        end else begin
            $display("FAIL quad_esc_pulse_generator_core");
        end
        $finish;
    end

endmodule
